@@ src/burst_ring_fifo_with_overwrite_defines.svh @@
// Assertion macros shared by the burst ring FIFO sources.
`ifndef BURST_RING_FIFO_WITH_OVERWRITE_DEFINES_SVH
`define BURST_RING_FIFO_WITH_OVERWRITE_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define BRF_ASSERT_ALWAYS(name, expr) \
name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
    else $error("brf: invariant violated");

// Check that a condition is followed by another in the next cycle.
`define BRF_ASSERT_NEXT(name, ante, cons) \
name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("brf: sequence violated");

`endif

@@ src/brf_pkg.sv @@
package brf_pkg;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned OUTQ_DEPTH = 4;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] POS_MAX = {CNT_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FORCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_STORE = 2'd0;
    localparam t_cmd_kind CMD_RES   = 2'd1;
    localparam t_cmd_kind CMD_READ  = 2'd2;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               emit;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic               status;
        logic [CNT_W-1:0]   moved;
        logic [CNT_W-1:0]   level;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   cap;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               final_res;
        logic               status;
        logic [CNT_W-1:0]   moved;
        logic [CNT_W-1:0]   level;
    } t_res;

endpackage

@@ src/brf_front.sv @@
`include "burst_ring_fifo_with_overwrite_defines.svh"

module brf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [brf_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic                         i_accept,
    input  logic [brf_pkg::FUNC_W-1:0]   i_func,
    input  logic [brf_pkg::CNT_W-1:0]    i_burst_len,
    input  logic [brf_pkg::DATA_W-1:0]   i_data,
    input  logic                         i_last,
    output logic                         o_cmd_vld,
    output brf_pkg::t_cmd                o_cmd
);
    import brf_pkg::*;

    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [ADDR_W-1:0] r_rd, n_rd;
    logic [ADDR_W-1:0] r_wr, n_wr;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_acc, n_acc;
    logic              r_err, n_err;

    logic              is_wr, first, bad, forced, over, do_drop, store, fin_wr;
    logic [CNT_W:0]    sum_fb, sum_rd, sum_rc;
    logic [CNT_W-1:0]  drop, room, fill_d, acc_d, pos_n, fill_w, moved_w, cnt, wr_inc;
    logic [ADDR_W-1:0] rd_d, rd_drop, rd_adv, wr_step;
    logic              err_d;
    logic [CNT_W:0]    chk_sum, chk_wrap;

    always_comb begin
        is_wr   = (i_func == FUNC_WRITE) || (i_func == FUNC_FORCE);
        forced  = (i_func == FUNC_FORCE);
        first   = (r_pos == '0);
        bad     = (i_burst_len == '0) || (i_burst_len > r_cap);
        sum_fb  = (CNT_W+1)'(r_fill) + (CNT_W+1)'(i_burst_len);
        over    = sum_fb > (CNT_W+1)'(r_cap);
        drop    = CNT_W'(sum_fb - (CNT_W+1)'(r_cap));
        sum_rd  = (CNT_W+1)'(r_rd) + (CNT_W+1)'(drop);
        rd_drop = (sum_rd >= (CNT_W+1)'(r_cap)) ?
                  ADDR_W'(sum_rd - (CNT_W+1)'(r_cap)) : ADDR_W'(sum_rd);
        do_drop = first && !bad && forced && over;
        fill_d  = do_drop ? (r_cap - i_burst_len) : r_fill;
        rd_d    = do_drop ? rd_drop : r_rd;
        room    = r_cap - r_fill;
        if (!first) begin
            acc_d = r_acc;
        end else if (bad) begin
            acc_d = '0;
        end else if (forced) begin
            acc_d = i_burst_len;
        end else begin
            acc_d = (i_burst_len < room) ? i_burst_len : room;
        end
        err_d   = first ? bad : r_err;
        store   = !err_d && (r_pos < acc_d) && (fill_d < r_cap);
        pos_n   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;
        fin_wr  = i_last || ((i_burst_len != '0) && (pos_n >= i_burst_len));
        fill_w  = fill_d + CNT_W'(store);
        moved_w = err_d ? '0 : ((pos_n < acc_d) ? pos_n : acc_d);
        wr_inc  = CNT_W'(r_wr) + 1'b1;
        wr_step = (wr_inc == r_cap) ? '0 : ADDR_W'(wr_inc);

        cnt     = (i_burst_len < r_fill) ? i_burst_len : r_fill;
        sum_rc  = (CNT_W+1)'(r_rd) + (CNT_W+1)'(cnt);
        rd_adv  = (sum_rc >= (CNT_W+1)'(r_cap)) ?
                  ADDR_W'(sum_rc - (CNT_W+1)'(r_cap)) : ADDR_W'(sum_rc);

        n_cap  = r_cap;
        n_rd   = r_rd;
        n_wr   = r_wr;
        n_fill = r_fill;
        n_pos  = r_pos;
        n_acc  = r_acc;
        n_err  = r_err;

        o_cmd_vld    = 1'b0;
        o_cmd.kind   = CMD_RES;
        o_cmd.emit   = 1'b1;
        o_cmd.addr   = r_wr;
        o_cmd.data   = i_data;
        o_cmd.status = 1'b0;
        o_cmd.moved  = '0;
        o_cmd.level  = r_fill;
        o_cmd.cnt    = cnt;
        o_cmd.cap    = r_cap;

        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data == '0) begin
                n_cap = CNT_W'(1);
            end else if (i_cfg_wr_data > CAP_MAX) begin
                n_cap = CAP_MAX;
            end else begin
                n_cap = i_cfg_wr_data;
            end
            n_rd   = '0;
            n_wr   = '0;
            n_fill = '0;
            n_pos  = '0;
            n_acc  = '0;
            n_err  = 1'b0;
        end else if (i_accept && is_wr) begin
            n_rd   = rd_d;
            n_fill = fill_w;
            n_wr   = store ? wr_step : r_wr;
            n_pos  = fin_wr ? '0 : pos_n;
            n_acc  = fin_wr ? '0 : acc_d;
            n_err  = fin_wr ? 1'b0 : err_d;
            o_cmd_vld    = store || fin_wr;
            o_cmd.kind   = store ? CMD_STORE : CMD_RES;
            o_cmd.emit   = fin_wr;
            o_cmd.status = err_d;
            o_cmd.moved  = moved_w;
            o_cmd.level  = fill_w;
        end else if (i_accept) begin
            n_pos     = '0;
            n_acc     = '0;
            n_err     = 1'b0;
            o_cmd_vld = 1'b1;
            if (i_func == FUNC_CLEAR) begin
                n_rd        = '0;
                n_wr        = '0;
                n_fill      = '0;
                o_cmd.level = '0;
            end else if (bad) begin
                o_cmd.status = 1'b1;
            end else if (cnt != '0) begin
                n_fill       = r_fill - cnt;
                n_rd         = (r_fill == cnt) ? '0 : rd_adv;
                n_wr         = (r_fill == cnt) ? '0 : r_wr;
                o_cmd.kind   = CMD_READ;
                o_cmd.addr   = r_rd;
                o_cmd.level  = r_fill - cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_MAX;
            r_rd   <= '0;
            r_wr   <= '0;
            r_fill <= '0;
            r_pos  <= '0;
            r_acc  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_cap  <= n_cap;
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_fill <= n_fill;
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_err  <= n_err;
        end
    end

    always_comb begin
        chk_sum  = (CNT_W+1)'(r_rd) + (CNT_W+1)'(r_fill);
        chk_wrap = (chk_sum >= (CNT_W+1)'(r_cap)) ? chk_sum - (CNT_W+1)'(r_cap) : chk_sum;
    end

    `BRF_ASSERT_ALWAYS(a_fill_in_cap, (r_fill <= r_cap) && (r_cap != '0) && (r_cap <= CAP_MAX))
    `BRF_ASSERT_ALWAYS(a_wr_tracks_rd, chk_wrap == (CNT_W+1)'(r_wr))
    `BRF_ASSERT_NEXT(a_burst_end_clears, i_accept && is_wr && fin_wr && !i_cfg_wr_en, (r_pos == '0) && !r_err)

endmodule

@@ src/brf_cmdq.sv @@
module brf_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brf_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_vld,
    output brf_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);
    import brf_pkg::*;

    localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
    localparam int unsigned CNT_QW = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_QW-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CNT_QW'(CMDQ_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_QW'(do_push) - CNT_QW'(do_pop);
        end
    end

endmodule

@@ src/brf_back.sv @@
`include "burst_ring_fifo_with_overwrite_defines.svh"

module brf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_vld,
    input  brf_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output brf_pkg::t_res  o_res
);
    import brf_pkg::*;

    localparam int unsigned OQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   r_mem_q;

    logic                r_busy;
    logic [ADDR_W-1:0]   r_addr;
    logic [CNT_W-1:0]    r_remain, r_total, r_level, r_cap;

    logic                r_s_vld, r_s_mem;
    t_res                r_s_res, n_s_res;

    t_res                r_oq [OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wp, r_oq_rp;
    logic [OQ_CNT_W-1:0] r_oq_cnt;

    logic                room, start, iter, wr_en, n_s_vld, oq_pop, last_iter;
    logic [CNT_W-1:0]    addr_inc;
    t_res                push_res;

    always_comb begin
        room      = (r_oq_cnt + OQ_CNT_W'(r_s_vld)) < OQ_CNT_W'(OUTQ_DEPTH);
        start     = !r_busy && i_cmd_vld && room;
        iter      = r_busy && room;
        wr_en     = start && (i_cmd.kind == CMD_STORE);
        last_iter = (r_remain == CNT_W'(1));
        n_s_vld   = (start && (i_cmd.kind != CMD_READ) && i_cmd.emit) || iter;
        addr_inc  = CNT_W'(r_addr) + 1'b1;

        n_s_res.read_data = '0;
        if (iter) begin
            n_s_res.final_res = last_iter;
            n_s_res.status    = 1'b0;
            n_s_res.moved     = last_iter ? r_total : '0;
            n_s_res.level     = r_level;
        end else begin
            n_s_res.final_res = 1'b1;
            n_s_res.status    = i_cmd.status;
            n_s_res.moved     = i_cmd.moved;
            n_s_res.level     = i_cmd.level;
        end

        push_res = r_s_res;
        if (r_s_mem) begin
            push_res.read_data = r_mem_q;
        end
    end

    assign o_cmd_pop = start;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_cmd.addr] <= i_cmd.data;
        end
        if (iter) begin
            r_mem_q <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= n_s_vld;
            if (start && (i_cmd.kind == CMD_READ)) begin
                r_busy <= 1'b1;
            end else if (iter && last_iter) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_res <= n_s_res;
        r_s_mem <= iter;
        if (start) begin
            r_addr   <= i_cmd.addr;
            r_remain <= i_cmd.cnt;
            r_total  <= i_cmd.cnt;
            r_level  <= i_cmd.level;
            r_cap    <= i_cmd.cap;
        end else if (iter) begin
            r_addr   <= (addr_inc == r_cap) ? '0 : ADDR_W'(addr_inc);
            r_remain <= r_remain - 1'b1;
        end
    end

    assign o_empty = (r_oq_cnt == '0);
    assign o_res   = r_oq[r_oq_rp];
    assign oq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s_vld) begin
            r_oq[r_oq_wp] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_s_vld) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(r_s_vld) - OQ_CNT_W'(oq_pop);
        end
    end

    `BRF_ASSERT_ALWAYS(a_oq_no_overflow, !r_s_vld || (r_oq_cnt < OQ_CNT_W'(OUTQ_DEPTH)) || oq_pop)
    `BRF_ASSERT_ALWAYS(a_busy_has_work, !r_busy || (r_remain != '0))
    `BRF_ASSERT_NEXT(a_read_fills_stage, iter, r_s_vld && r_s_mem)

endmodule

@@ src/burst_ring_fifo_with_overwrite.sv @@
// Channel   Handshake                 Fields
// input     push / full               i_func i_burst_len i_data i_last
// result    empty / pop               o_read_data o_final_res o_status o_moved o_level
// config    i_cfg_wr_en               i_cfg_wr_data (capacity)
//
// Write, clear and bad requests are handled by the front end as they are accepted; a read of n
// elements holds the back end for a load step and then one memory read per element.
// Results of a write, clear or bad request pass through the result stage and the result queue
// to the outputs; the elements of a read follow the load step and the memory read register.
// Reset is synchronous and active low; capacity resets to 64, the queue to empty.
// A full result queue stalls the back end; a full command queue raises full.
module burst_ring_fifo_with_overwrite (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [brf_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic                         push,
    output logic                         full,
    input  logic [brf_pkg::FUNC_W-1:0]   i_func,
    input  logic [brf_pkg::CNT_W-1:0]    i_burst_len,
    input  logic [brf_pkg::DATA_W-1:0]   i_data,
    input  logic                         i_last,
    output logic                         empty,
    input  logic                         pop,
    output logic [brf_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_final_res,
    output logic                         o_status,
    output logic [brf_pkg::CNT_W-1:0]    o_moved,
    output logic [brf_pkg::CNT_W-1:0]    o_level
);
    import brf_pkg::*;

    logic accept;
    logic cmd_vld, q_vld, q_pop;
    t_cmd cmd, q_cmd;
    t_res res;

    assign accept = push && !full;

    brf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_burst_len   (i_burst_len),
        .i_data        (i_data),
        .i_last        (i_last),
        .o_cmd_vld     (cmd_vld),
        .o_cmd         (cmd)
    );

    brf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_vld),
        .i_cmd   (cmd),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    brf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (q_cmd),
        .o_cmd_pop (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_read_data = res.read_data;
    assign o_final_res = res.final_res;
    assign o_status    = res.status;
    assign o_moved     = res.moved;
    assign o_level     = res.level;

endmodule
